[hdl/drrip_streaming_replacement_unit_assert.svh]
// assertion macros shared by the checker files
`ifndef DRRIP_STREAMING_REPLACEMENT_UNIT_ASSERT_SVH
`define DRRIP_STREAMING_REPLACEMENT_UNIT_ASSERT_SVH

// clocked property, switched off while reset is asserted
`define DRRIP_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("drrip check failed");

// clocked property that also holds through reset
`define DRRIP_ASSERT_ALL(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("drrip check failed");

`endif

[hdl/drrip_pkg.sv]
package drrip_pkg;

    localparam int SET_IN_W = 11;
    localparam int WAY_W    = 4;
    localparam int ADDR_W   = 8;
    localparam int DRAW_W   = 5;
    localparam int SCORE_W  = 4;
    localparam int RRPV_W   = 2;
    localparam int PSEL_W   = 10;
    localparam int THR_W    = 4;

    localparam logic FUNC_VICTIM = 1'b0;
    localparam logic FUNC_UPDATE = 1'b1;

    localparam logic [RRPV_W-1:0] RRPV_NEAR  = 2'd0;
    localparam logic [RRPV_W-1:0] RRPV_LONG  = 2'd2;
    localparam logic [RRPV_W-1:0] RRPV_MAX   = 2'd3;
    localparam logic [RRPV_W-1:0] RRPV_RESET = 2'd2;

    localparam logic [SCORE_W-1:0] SCORE_MAX    = 4'd15;
    localparam logic [THR_W-1:0]   THRESH_RESET = 4'd10;

    localparam logic [PSEL_W-1:0] PSEL_INIT = 10'd512;
    localparam logic [PSEL_W-1:0] PSEL_MAX  = 10'd1023;

    typedef struct packed {
        logic                func;
        logic [WAY_W-1:0]    way;
        logic [ADDR_W-1:0]   addr;
        logic                hit;
        logic [DRAW_W-1:0]   draw;
    } drrip_req_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic [ADDR_W-1:0]  last;
    } drrip_side_t;

    typedef struct packed {
        logic             lead_s;
        logic             lead_b;
        logic             srrip_wins;
        logic [THR_W-1:0] thresh;
    } drrip_pol_t;

    typedef struct packed {
        logic              streaming;
        logic [RRPV_W-1:0] ins;
        logic [WAY_W-1:0]  victim;
    } drrip_res_t;

endpackage

[hdl/drrip_ram.sv]
module drrip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // read returns the old contents when both ports hit one entry
    always_ff @(posedge clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hdl/drrip_row_update.sv]
module drrip_row_update #(
    parameter int NUM_WAYS = 16
) (
    input  logic [2*NUM_WAYS-1:0] row_in,
    input  drrip_pkg::drrip_side_t side_in,
    input  drrip_pkg::drrip_req_t  req,
    input  drrip_pkg::drrip_pol_t  pol,
    output logic [2*NUM_WAYS-1:0] row_out,
    output drrip_pkg::drrip_side_t side_out,
    output drrip_pkg::drrip_res_t  res
);

    logic                                any3;
    logic                                any_hi;
    logic                                any_lo;
    logic [drrip_pkg::RRPV_W-1:0]        maxv;
    logic [drrip_pkg::RRPV_W-1:0]        age;
    logic [2*NUM_WAYS-1:0]               aged;
    logic [2*NUM_WAYS-1:0]               row_upd;
    logic [drrip_pkg::WAY_W-1:0]         victim;
    logic [drrip_pkg::ADDR_W-1:0]        delta;
    logic                                stride;
    logic [drrip_pkg::SCORE_W-1:0]       score_upd;
    logic                                stream_upd;
    logic                                brrip_ins;
    logic [drrip_pkg::RRPV_W-1:0]        brrip_val;
    logic [drrip_pkg::RRPV_W-1:0]        ins;

    // aging: lift every way by the distance of the largest value to 3
    always_comb begin
        any3   = 1'b0;
        any_hi = 1'b0;
        any_lo = 1'b0;
        for (int w = 0; w < NUM_WAYS; w++) begin
            any3   = any3 | (row_in[2*w +: 2] == drrip_pkg::RRPV_MAX);
            any_hi = any_hi | row_in[2*w + 1];
            any_lo = any_lo | row_in[2*w];
        end
        if (any3) begin
            maxv = drrip_pkg::RRPV_MAX;
        end else if (any_hi) begin
            maxv = 2'd2;
        end else if (any_lo) begin
            maxv = 2'd1;
        end else begin
            maxv = 2'd0;
        end
        age = drrip_pkg::RRPV_MAX - maxv;
        for (int w = 0; w < NUM_WAYS; w++) begin
            aged[2*w +: 2] = row_in[2*w +: 2] + age;
        end
        victim = '0;
        for (int w = NUM_WAYS - 1; w >= 0; w--) begin
            if (aged[2*w +: 2] == drrip_pkg::RRPV_MAX) begin
                victim = drrip_pkg::WAY_W'(w);
            end
        end
    end

    // stride test keeps the comparison of delta with the stored byte
    always_comb begin
        delta  = req.addr - side_in.last;
        stride = (side_in.last != '0) &&
                 ((delta == side_in.last) || (delta == 8'd1) || (delta == 8'hFF));
        if (stride) begin
            score_upd = (side_in.score != drrip_pkg::SCORE_MAX) ?
                        side_in.score + 4'd1 : side_in.score;
        end else begin
            score_upd = (side_in.score != '0) ? side_in.score - 4'd1 : side_in.score;
        end
        stream_upd = (score_upd >= pol.thresh);
    end

    always_comb begin
        brrip_val = (req.draw == '0) ? drrip_pkg::RRPV_NEAR : drrip_pkg::RRPV_LONG;
        brrip_ins = pol.lead_b || (!pol.lead_s && !pol.srrip_wins);
        if (req.hit) begin
            ins = drrip_pkg::RRPV_NEAR;
        end else if (stream_upd) begin
            ins = drrip_pkg::RRPV_MAX;
        end else if (brrip_ins && !pol.lead_s) begin
            ins = brrip_val;
        end else begin
            ins = drrip_pkg::RRPV_NEAR;
        end
        // an out of range way matches no slot, so the write is dropped
        row_upd = row_in;
        for (int w = 0; w < NUM_WAYS; w++) begin
            if (int'(req.way) == w) begin
                row_upd[2*w +: 2] = ins;
            end
        end
    end

    always_comb begin
        if (req.func == drrip_pkg::FUNC_VICTIM) begin
            row_out       = aged;
            side_out      = side_in;
            res.victim    = victim;
            res.ins       = drrip_pkg::RRPV_MAX;
            res.streaming = (side_in.score >= pol.thresh);
        end else begin
            row_out        = row_upd;
            side_out.score = score_upd;
            side_out.last  = req.addr;
            res.victim     = req.way;
            res.ins        = ins;
            res.streaming  = stream_upd;
        end
    end

endmodule

[hdl/drrip_streaming_replacement_unit.sv]
// Replacement engine for a last-level cache: per-way 2-bit re-reference values with set-dueling
// insertion and a per-set streaming score. One item is accepted per cycle while the output is not
// stalled; each item's memory read is registered in the s1 stage and its result then in the output
// register. The rate is set by the single read-modify-write of the set row and side memories, with
// the written row forwarded when the next item hits the same set. After reset the memories are
// swept once, one set per cycle over all NUM_SETS sets (2048 by default), while s_tready stays low;
// threshold writes are taken throughout.
module drrip_streaming_replacement_unit #(
    parameter int NUM_SETS    = 2048,
    parameter int NUM_WAYS    = 16,
    parameter int LEADER_SETS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // set_index[10:0], way_index[14:11], block_addr_byte[22:15], hit[23],
    // random_draw[28:24], zero fill above
    input  logic [31:0] s_tdata,
    // func[0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // victim_way[3:0], inserted_value[5:4], set_streaming[6], zero fill above
    output logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    localparam int SW     = $clog2(NUM_SETS);
    localparam int ROW_W  = 2 * NUM_WAYS;
    localparam int SIDE_W = $bits(drrip_pkg::drrip_side_t);

    logic [drrip_pkg::THR_W-1:0]  thresh_reg;
    logic [drrip_pkg::PSEL_W-1:0] psel_reg;
    logic                         clr_active_reg;
    logic [SW-1:0]                clr_idx_reg;
    logic                         s1_valid_reg;
    drrip_pkg::drrip_req_t        s1_req_reg;
    logic [SW-1:0]                s1_set_reg;
    logic                         s1_fwd_reg;
    logic [ROW_W-1:0]             fwd_row_reg;
    drrip_pkg::drrip_side_t       fwd_side_reg;
    logic                         m_valid_reg;
    logic [7:0]                   m_data_reg;

    logic                   accept;
    logic                   advance;
    logic [15:0]            set_mod;
    logic [SW-1:0]          in_set;
    drrip_pkg::drrip_req_t  in_req;
    logic [ROW_W-1:0]       ram_row;
    logic [SIDE_W-1:0]      ram_side;
    logic [ROW_W-1:0]       cur_row;
    drrip_pkg::drrip_side_t cur_side;
    logic [ROW_W-1:0]       new_row;
    drrip_pkg::drrip_side_t new_side;
    drrip_pkg::drrip_res_t  res;
    drrip_pkg::drrip_pol_t  pol;
    logic                   we;
    logic [SW-1:0]          waddr;
    logic [ROW_W-1:0]       wrow;
    logic [SIDE_W-1:0]      wside;
    logic                   lead_s;
    logic                   lead_b;

    // set index folded into range by restoring subtraction of shifted set counts
    always_comb begin
        set_mod = 16'(s_tdata[drrip_pkg::SET_IN_W-1:0]);
        for (int k = 3; k >= 0; k--) begin
            if (32'(set_mod) >= (NUM_SETS << k)) begin
                set_mod = set_mod - 16'(NUM_SETS << k);
            end
        end
        in_set = set_mod[SW-1:0];
    end

    always_comb begin
        in_req.func = s_tuser;
        in_req.way  = s_tdata[14:11];
        in_req.addr = s_tdata[22:15];
        in_req.hit  = s_tdata[23];
        in_req.draw = s_tdata[28:24];
    end

    assign advance   = s1_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready  = !clr_active_reg && (!s1_valid_reg || advance);
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = m_data_reg;

    assign lead_s = (32'(s1_set_reg) < LEADER_SETS);
    assign lead_b = (32'(s1_set_reg) >= NUM_SETS - LEADER_SETS);

    always_comb begin
        pol.lead_s     = lead_s;
        pol.lead_b     = lead_b;
        pol.srrip_wins = (psel_reg >= drrip_pkg::PSEL_INIT);
        pol.thresh     = thresh_reg;
    end

    // the row written in the cycle of the transfer is not yet in the read data
    assign cur_row  = s1_fwd_reg ? fwd_row_reg : ram_row;
    assign cur_side = s1_fwd_reg ? fwd_side_reg : drrip_pkg::drrip_side_t'(ram_side);

    always_comb begin
        if (clr_active_reg) begin
            we    = 1'b1;
            waddr = clr_idx_reg;
            wrow  = {NUM_WAYS{drrip_pkg::RRPV_RESET}};
            wside = '0;
        end else begin
            we    = advance;
            waddr = s1_set_reg;
            wrow  = new_row;
            wside = SIDE_W'(new_side);
        end
    end

    drrip_ram #(
        .WIDTH (ROW_W),
        .DEPTH (NUM_SETS)
    ) u_row_ram (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wrow),
        .re    (accept),
        .raddr (in_set),
        .rdata (ram_row)
    );

    drrip_ram #(
        .WIDTH (SIDE_W),
        .DEPTH (NUM_SETS)
    ) u_side_ram (
        .clk   (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wside),
        .re    (accept),
        .raddr (in_set),
        .rdata (ram_side)
    );

    drrip_row_update #(
        .NUM_WAYS (NUM_WAYS)
    ) u_update (
        .row_in   (cur_row),
        .side_in  (cur_side),
        .req      (s1_req_reg),
        .pol      (pol),
        .row_out  (new_row),
        .side_out (new_side),
        .res      (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thresh_reg     <= drrip_pkg::THRESH_RESET;
            psel_reg       <= drrip_pkg::PSEL_INIT;
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
            s1_valid_reg   <= 1'b0;
            s1_fwd_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                thresh_reg <= cfg_data;
            end
            if (clr_active_reg) begin
                clr_idx_reg <= clr_idx_reg + 1'b1;
                if (clr_idx_reg == SW'(NUM_SETS - 1)) begin
                    clr_active_reg <= 1'b0;
                end
            end
            if (accept) begin
                s1_valid_reg <= 1'b1;
                s1_fwd_reg   <= advance && (in_set == s1_set_reg);
            end else if (advance) begin
                s1_valid_reg <= 1'b0;
            end
            if (advance) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
            // only leader misses move the selector
            if (advance && s1_req_reg.func == drrip_pkg::FUNC_UPDATE && !s1_req_reg.hit) begin
                if (lead_s) begin
                    if (psel_reg != '0) begin
                        psel_reg <= psel_reg - 1'b1;
                    end
                end else if (lead_b) begin
                    if (psel_reg != drrip_pkg::PSEL_MAX) begin
                        psel_reg <= psel_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_req_reg <= in_req;
            s1_set_reg <= in_set;
        end
        if (advance) begin
            fwd_row_reg  <= new_row;
            fwd_side_reg <= new_side;
            m_data_reg   <= {1'b0, res.streaming, res.ins, res.victim};
        end
    end

endmodule

[hdl/drrip_checker.sv]
`include "drrip_streaming_replacement_unit_assert.svh"

module drrip_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       s_tuser,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata
);

    // no result is left pending across reset
    `DRRIP_ASSERT_ALL(a_reset_clears_out, aclk, !aresetn |=> !m_tvalid)

    // memory sweep blocks input right after reset
    `DRRIP_ASSERT_ALL(a_sweep_blocks_in, aclk, $rose(aresetn) |-> !s_tready)

    // a fresh result always follows a transfer, by way of the s1 and output registers
    `DRRIP_ASSERT_RST(a_out_follows_in, aclk, aresetn, $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))

    // victim requests report the most distant value
    `DRRIP_ASSERT_RST(a_victim_value, aclk, aresetn, $rose(m_tvalid) && $past(s_tuser == drrip_pkg::FUNC_VICTIM, 2) |-> m_tdata[5:4] == drrip_pkg::RRPV_MAX)

    // a stalled result holds
    `DRRIP_ASSERT_RST(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

endmodule

bind drrip_streaming_replacement_unit drrip_checker u_drrip_checker (.*);
